>>> hdl/bfc_pkg.sv
// Shared types and constants for the block framer with CRC-16 trailer.
// Holds the front-to-back command format and the Modbus CRC byte fold.
// No dependencies.
`default_nettype none

package bfc_pkg;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam int          TRAILER_BYTES = 3;
   localparam logic [7:0]  PAYLOAD_LIMIT = 8'd252;
   localparam int          CMD_DEPTH     = 4;

   typedef enum logic [1:0] {
      OP_PAY,
      OP_OVF,
      OP_END
   } op_type;

   // one classified request, as queued between front and back
   typedef struct packed {
      op_type      op;
      logic [7:0]  data;   // payload byte, or frame length for OP_END
      logic [15:0] crc;    // final CRC for OP_END
      logic        hold;   // OP_END: defer the CRC low byte to the next request
   } cmd_type;

   // fold one byte into a reflected CRC-16, eight bit steps
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] x;
      x = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      end
      return x;
   endfunction

endpackage

`default_nettype wire

>>> hdl/block_framer_with_crc_trailer.sv
// Block framer with Modbus CRC-16 trailer. Payload bytes (req_kind = 0) pass
// into blocks of BLOCK_BYTES bytes; an end marker (req_kind = 1) adds zero
// padding and a trailer of length, CRC high and CRC low in the last three
// positions of a block, opening a new block when fewer than three remain.
// Bytes past 252 in a frame are dropped, each reported by an overflow result.
// The front takes one request per clock while its four-entry command queue
// has room; the back delivers one result byte per clock while rsp_pop drains
// the output register, emitting the padding and trailer of an end marker in
// turn. When an end marker arrives with two positions left in a block, the
// trailer's final byte is held back and released just before the results of
// the next accepted request. No memory clearing after reset.
`default_nettype none

module block_framer_with_crc_trailer #(
   parameter int BLOCK_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_block_end,
   output logic             rsp_frame_end,
   output logic             rsp_overflow
);

   bfc_pkg::cmd_type enq_cmd, head;
   logic             enq, q_full, q_valid, q_pop;

   assign req_full = q_full;

   bfc_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .kind      (req_kind),
      .data_byte (req_data_byte),
      .q_full    (q_full),
      .cmd       (enq_cmd),
      .enq       (enq)
   );

   bfc_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .enq       (enq),
      .enq_cmd   (enq_cmd),
      .deq       (q_pop),
      .head      (head),
      .full      (q_full),
      .not_empty (q_valid)
   );

   bfc_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .head          (head),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_block_end (rsp_block_end),
      .rsp_frame_end (rsp_frame_end),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire

>>> hdl/bfc_front.sv
// Front part of the block framer: accepts requests, runs the CRC, payload
// count and block position, and turns each request into a queued command.
// Depends on bfc_pkg.
`default_nettype none

module bfc_front #(
   parameter int BLOCK_BYTES = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire logic            kind,
   input  wire logic [7:0]      data_byte,
   input  wire logic            q_full,
   output bfc_pkg::cmd_type     cmd,
   output logic                 enq
);

   localparam int POS_W = $clog2(BLOCK_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);
   localparam logic [POS_W-1:0] POS_HOLD = POS_W'(BLOCK_BYTES - 2);

   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   assign enq = push && !q_full;

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      cmd      = '{op: bfc_pkg::OP_PAY, data: data_byte, crc: crc_ff, hold: 1'b0};
      if (kind) begin
         // close the frame; hold the last byte when two positions are left in the block
         cmd.op   = bfc_pkg::OP_END;
         cmd.data = count_ff;
         cmd.hold = (pos_ff == POS_HOLD);
         crc_in   = bfc_pkg::CRC_INIT;
         count_in = '0;
         pos_in   = '0;
      end else if (count_ff < bfc_pkg::PAYLOAD_LIMIT) begin
         crc_in   = bfc_pkg::crc_fold(crc_ff, data_byte);
         count_in = count_ff + 8'd1;
         pos_in   = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
      end else begin
         cmd.op = bfc_pkg::OP_OVF;   // drop the byte
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= bfc_pkg::CRC_INIT;
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (enq) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/bfc_cmd_fifo.sv
// Short command queue between the front and back parts of the framer.
// Depends on bfc_pkg.
`default_nettype none

module bfc_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enq,
   input  wire bfc_pkg::cmd_type enq_cmd,
   input  wire logic             deq,
   output bfc_pkg::cmd_type      head,
   output logic                  full,
   output logic                  not_empty
);

   localparam int PTR_W = $clog2(bfc_pkg::CMD_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   bfc_pkg::cmd_type  mem_ff [bfc_pkg::CMD_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full      = (count_ff == CNT_W'(bfc_pkg::CMD_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (enq) begin
         mem_ff[wr_ptr_ff] <= enq_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (enq) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (deq) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (enq && !deq)      count_ff <= count_ff + CNT_W'(1);
         else if (!enq && deq) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

>>> hdl/bfc_back.sv
// Back part of the framer: expands queued commands into the byte stream,
// pads blocks, appends the length and CRC trailer, and holds the output register.
// Depends on bfc_pkg.
`default_nettype none

module bfc_back #(
   parameter int BLOCK_BYTES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire bfc_pkg::cmd_type head,
   output logic                  q_pop,
   input  wire logic             rsp_pop,
   output logic                  rsp_empty,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_block_end,
   output logic                  rsp_frame_end,
   output logic                  rsp_overflow
);

   localparam int POS_W = $clog2(BLOCK_BYTES);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);
   localparam logic [POS_W-1:0] TRAILER_AT = POS_W'(BLOCK_BYTES - bfc_pkg::TRAILER_BYTES);

   typedef enum logic [1:0] {
      PH_START,
      PH_PAD,
      PH_HI,
      PH_LO
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             wrap_ff, wrap_in;
   logic [7:0]       len_ff, len_in;
   logic [15:0]      crc_ff, crc_in;
   logic             hold_ff, hold_in;
   logic             held_ff, held_in;
   logic [7:0]       held_byte_ff, held_byte_in;

   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_be_ff, out_fe_ff, out_ov_ff;

   logic             out_ready;
   logic             emit;
   logic [7:0]       e_byte;
   logic             e_be, e_fe, e_ov;
   logic             last;
   logic             pad_w;
   logic [7:0]       pad_len;

   assign out_ready = !out_valid_ff || rsp_pop;
   assign last      = (pos_ff == POS_LAST);
   assign pad_w     = (phase_ff == PH_START) ? (pos_ff > TRAILER_AT) : wrap_ff;
   assign pad_len   = (phase_ff == PH_START) ? head.data : len_ff;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      wrap_in      = wrap_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      hold_in      = hold_ff;
      held_in      = held_ff;
      held_byte_in = held_byte_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      e_byte       = '0;
      e_be         = 1'b0;
      e_fe         = 1'b0;
      e_ov         = 1'b0;
      if (out_ready) begin
         unique case (phase_ff)
            PH_START: begin
               if (q_valid) begin
                  if (held_ff) begin
                     // release the deferred CRC low byte ahead of the new request
                     emit    = 1'b1;
                     e_byte  = held_byte_ff;
                     e_be    = 1'b1;
                     e_fe    = 1'b1;
                     pos_in  = '0;
                     held_in = 1'b0;
                  end else begin
                     unique case (head.op)
                        bfc_pkg::OP_PAY: begin
                           q_pop  = 1'b1;
                           emit   = 1'b1;
                           e_byte = head.data;
                           e_be   = last;
                           pos_in = last ? '0 : pos_ff + POS_W'(1);
                        end
                        bfc_pkg::OP_OVF: begin
                           q_pop = 1'b1;
                           emit  = 1'b1;
                           e_ov  = 1'b1;
                        end
                        bfc_pkg::OP_END: begin
                           q_pop   = 1'b1;
                           crc_in  = head.crc;
                           hold_in = head.hold;
                           len_in  = head.data;
                           phase_in = PH_PAD;
                        end
                        default: ;
                     endcase
                  end
               end
            end
            PH_PAD, PH_HI, PH_LO: ;
            default: ;
         endcase

         // pad and trailer steps, entered straight from an end command too
         if (phase_in == PH_PAD) begin
            emit = 1'b1;
            e_be = last;
            if (pad_w || pos_ff != TRAILER_AT) begin
               e_byte  = '0;
               pos_in  = last ? '0 : pos_ff + POS_W'(1);
               wrap_in = pad_w && !last;
            end else begin
               e_byte   = pad_len;
               pos_in   = pos_ff + POS_W'(1);
               wrap_in  = 1'b0;
               phase_in = PH_HI;
            end
         end else if (phase_ff == PH_HI) begin
            emit   = 1'b1;
            e_byte = crc_ff[15:8];
            e_be   = last;
            pos_in = last ? '0 : pos_ff + POS_W'(1);
            if (hold_ff) begin
               held_in      = 1'b1;
               held_byte_in = crc_ff[7:0];
               phase_in     = PH_START;
            end else begin
               phase_in = PH_LO;
            end
         end else if (phase_ff == PH_LO) begin
            emit     = 1'b1;
            e_byte   = crc_ff[7:0];
            e_be     = 1'b1;
            e_fe     = 1'b1;
            pos_in   = '0;
            phase_in = PH_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         pos_ff       <= '0;
         wrap_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         held_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         wrap_ff  <= wrap_in;
         hold_ff  <= hold_in;
         held_ff  <= held_in;
         if (out_ready) out_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      crc_ff       <= crc_in;
      held_byte_ff <= held_byte_in;
      if (out_ready && emit) begin
         out_byte_ff <= e_byte;
         out_be_ff   <= e_be;
         out_fe_ff   <= e_fe;
         out_ov_ff   <= e_ov;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_block_end = out_be_ff;
   assign rsp_frame_end = out_fe_ff;
   assign rsp_overflow  = out_ov_ff;

endmodule

`default_nettype wire

>>> hdl/bfc_checker.sv
// Port-level checks for the block framer, bound to the top level.
// No dependencies.
`default_nettype none

module bfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_block_end,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_overflow
);

   a_frame_end_closes_block: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_block_end)
      else $error("frame end without block end");

   a_overflow_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_overflow) |->
         (rsp_out_byte == 8'h00 && !rsp_block_end && !rsp_frame_end))
      else $error("overflow result carries stream data");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("not empty after reset");

endmodule

bind block_framer_with_crc_trailer bfc_checker u_bfc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_block_end (rsp_block_end),
   .rsp_frame_end (rsp_frame_end),
   .rsp_overflow  (rsp_overflow)
);

`default_nettype wire
